FILE: src/ctc_pkg.sv
package ctc_pkg;

  localparam int CHANNELS = 4;
  localparam int CH_W     = 2;   // width of the channel field
  localparam int CNT_W    = 17;  // down counter width

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // control word bits
  localparam int CW_INT_EN  = 7;
  localparam int CW_COUNTER = 6;
  localparam int CW_PRE256  = 5;
  localparam int CW_TC_NEXT = 2;
  localparam int CW_RESET   = 1;
  localparam int CW_CONTROL = 0;

  localparam logic [7:0] VEC_MASK = 8'hF8;

  typedef enum logic [1:0] {
    FUNC_WR   = 2'd0,
    FUNC_RD   = 2'd1,
    FUNC_TICK = 2'd2,
    FUNC_NOP  = 2'd3
  } ctc_func_t;

  // per-channel command from the top level
  typedef struct packed {
    logic       wr;       // bus write to this channel
    logic       tick;     // time tick
    logic       clr_irq;  // interrupt delivered for this channel
    logic [7:0] data;
    logic [7:0] cycles;
  } ctc_chan_cmd_t;

  // per-channel status back to the top level
  typedef struct packed {
    logic       await_tc;  // current state, before this beat
    logic       irq_tick;  // flag after this beat's tick, before delivery
    logic [7:0] rd_val;    // prescaled count
  } ctc_chan_st_t;

endpackage

FILE: src/counter_timer_with_int_priority_unit.sv
// Four-channel counter/timer with prioritized interrupt delivery.
// Input stream (in_*): one beat per bus write, bus read or time tick.
//   A write loads a pending time constant, the channel 0 vector base
//   (bit 0 clear) or a control word. A read returns the down count divided
//   by the prescale (16 or 256). A tick subtracts elapsed cycles from every
//   running timer; on expiry the channel reloads and raises its flag if
//   enabled, and when int_accept is set the lowest flagged channel is
//   delivered with vector base | channel*2.
// Output stream (out_*): exactly one result beat per input beat, in order.
// Path: a beat is held in the input register, then processed into the result
//   register when it advances, and presented on out_* from then on.
// Throughput: one beat per cycle while out_tready is high; all channels update
//   in parallel logic between the input register and the result register.
// Reset (rst_n low, synchronous): all channel state, vector base and both
//   pipeline registers clear; no beats are in flight afterwards.
// Stall: if out_tready is low the result register holds, the input register
//   holds its beat and in_tready drops once both are full.
module counter_timer_with_int_priority_unit
  import ctc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] func, [3:2] channel, [11:4] write_data, [19:12] elapsed_cycles,
  // [20] int_accept, [23:21] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] read_data, [8] int_request, [16:9] int_vector, [23:17] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // input register
  logic                  s1_v_r;
  logic [IN_TDATA_W-1:0] s1_data_r;
  // result register
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [7:0]             vbase_r, vbase_nxt;

  logic advance;  // s1 beat is processed and moves to the result register

  ctc_func_t  func;
  logic [CH_W-1:0] chan;
  logic [7:0] wdata;
  logic [7:0] cycles;
  logic       accept;

  ctc_chan_cmd_t       cmd [CHANNELS];
  ctc_chan_st_t        st  [CHANNELS];
  logic [CHANNELS-1:0] irq_req;
  logic [CHANNELS-1:0] grant;
  logic                hit;
  logic [CH_W-1:0]     hit_idx;
  logic [7:0]          rd_data;
  logic                is_tick;

  assign advance   = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = !s1_v_r || advance;

  assign func   = ctc_func_t'(s1_data_r[1:0]);
  assign chan   = s1_data_r[3:2];
  assign wdata  = s1_data_r[11:4];
  assign cycles = s1_data_r[19:12];
  assign accept = s1_data_r[20];
  assign is_tick = (func == FUNC_TICK);

  // delivery happens only on ticks with int_accept set
  ctc_prio u_prio (
    .req   (irq_req),
    .hit   (hit),
    .idx   (hit_idx),
    .grant (grant)
  );

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_ch
      always_comb begin
        cmd[g].wr      = (func == FUNC_WR) && (chan == CH_W'(g));
        cmd[g].tick    = is_tick;
        cmd[g].clr_irq = is_tick && accept && grant[g];
        cmd[g].data    = wdata;
        cmd[g].cycles  = cycles;
      end
      assign irq_req[g] = st[g].irq_tick && is_tick && accept;

      ctc_channel u_ch (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cmd   (cmd[g]),
        .st    (st[g])
      );
    end
  endgenerate

  // read mux; read_data is zero on beats other than reads
  always_comb begin
    rd_data = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if ((func == FUNC_RD) && (chan == CH_W'(c))) rd_data = st[c].rd_val;
    end
  end

  // vector base: channel 0 write, no constant pending, bit 0 clear
  always_comb begin
    vbase_nxt = vbase_r;
    if ((func == FUNC_WR) && (chan == '0) && !st[0].await_tc && !wdata[CW_CONTROL]) begin
      vbase_nxt = wdata & VEC_MASK;
    end
  end

  always_comb begin
    out_data_nxt       = '0;
    out_data_nxt[7:0]  = rd_data;
    out_data_nxt[8]    = hit;
    if (hit) out_data_nxt[16:9] = {vbase_r[7:3], hit_idx, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      vbase_r <= '0;
    end else begin
      if (in_tready) s1_v_r <= in_tvalid;
      if (advance) begin
        out_v_r <= 1'b1;
        vbase_r <= vbase_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_data_r <= in_tdata;
    if (advance) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/ctc_channel.sv
module ctc_channel
  import ctc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  ctc_chan_cmd_t cmd,
  output ctc_chan_st_t  st
);

  logic [7:0]       cw_r, cw_nxt;
  logic [7:0]       tc_r, tc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             await_r, await_nxt;
  logic             irq_r, irq_nxt;
  logic             irq_tick;
  logic [CNT_W-1:0] reload_cur;
  logic [CNT_W-1:0] reload_new;
  logic             running;

  // (tc, zero meaning 256) times 16 or 256
  function automatic logic [CNT_W-1:0] reload_of(input logic [7:0] tc, input logic pre256);
    logic [8:0] t9;
    begin
      t9 = (tc == 8'd0) ? 9'd256 : {1'b0, tc};
      reload_of = pre256 ? CNT_W'({t9, 8'd0}) : CNT_W'({t9, 4'd0});
    end
  endfunction

  assign reload_cur = reload_of(tc_r, cw_r[CW_PRE256]);
  assign reload_new = reload_of(cmd.data, cw_r[CW_PRE256]);
  assign running    = cw_r[CW_CONTROL] && !cw_r[CW_COUNTER] && (cnt_r != '0);

  always_comb begin
    cw_nxt    = cw_r;
    tc_nxt    = tc_r;
    cnt_nxt   = cnt_r;
    await_nxt = await_r;
    irq_tick  = irq_r;
    if (cmd.wr) begin
      if (await_r) begin
        tc_nxt    = cmd.data;
        await_nxt = 1'b0;
        cnt_nxt   = reload_new;
      end else if (cmd.data[CW_CONTROL]) begin
        cw_nxt = cmd.data;
        if (cmd.data[CW_TC_NEXT]) await_nxt = 1'b1;
        if (cmd.data[CW_RESET]) begin
          cnt_nxt  = '0;
          irq_tick = 1'b0;
        end
      end
    end else if (cmd.tick && running) begin
      if (CNT_W'(cmd.cycles) >= cnt_r) begin
        cnt_nxt = reload_cur;
        if (cw_r[CW_INT_EN]) irq_tick = 1'b1;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(cmd.cycles);
      end
    end
    irq_nxt = irq_tick && !cmd.clr_irq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r    <= '0;
      tc_r    <= '0;
      cnt_r   <= '0;
      await_r <= 1'b0;
      irq_r   <= 1'b0;
    end else if (en) begin
      cw_r    <= cw_nxt;
      tc_r    <= tc_nxt;
      cnt_r   <= cnt_nxt;
      await_r <= await_nxt;
      irq_r   <= irq_nxt;
    end
  end

  assign st.await_tc = await_r;
  assign st.irq_tick = irq_tick;
  assign st.rd_val   = cw_r[CW_PRE256] ? cnt_r[15:8] : cnt_r[11:4];

endmodule

FILE: src/ctc_prio.sv
module ctc_prio
  import ctc_pkg::*;
(
  input  logic [CHANNELS-1:0] req,
  output logic                hit,
  output logic [CH_W-1:0]     idx,
  output logic [CHANNELS-1:0] grant
);

  // lowest channel wins
  always_comb begin
    hit   = 1'b0;
    idx   = '0;
    grant = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (req[c]) begin
        hit   = 1'b1;
        idx   = CH_W'(c);
        grant = CHANNELS'(1) << c;
      end
    end
  end

endmodule
